@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check with asynchronous reset disable
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ hw/rtl/fwps_pkg.sv @@
// Shared types and constants of the four-way partition search
package fwps_pkg;
	localparam int SIDES = 4;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_SORT_RD,
		ST_SORT_CMP,
		ST_SORT_WR,
		ST_LEVEL_RD,
		ST_TRY,
		ST_BACK,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // store an incoming length
		logic clr_set;    // clear set state after the result
		logic sort_init;  // start insertion sort
		logic sort_rd;    // read key, set hole
		logic sort_cmp;   // compare step
		logic sort_wr;    // write back
		logic srch_init;  // clear sides, level 0
		logic lvl_rd;     // read length at current level
		logic try_side;   // attempt current side
		logic back;       // backtrack one level
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic trivial_fail; // overflow, too few, or total not multiple of 4
		logic sort_done;
		logic sort_shift;   // fetch pending, or element smaller than key: shift and continue
		logic level_end;    // all lengths placed
		logic all_equal;
		logic side_ok;      // current side accepts the length
		logic sides_left;   // current side index < SIDES
		logic at_root;      // level 0 on backtrack
	} dp_stat_t;
endpackage

@@ hw/rtl/fwps_ctrl.sv @@
// Controller state machine of the partition search
module fwps_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic in_last,
	input  logic out_busy,
	input  fwps_pkg::dp_stat_t stat,
	output fwps_pkg::dp_cmd_t cmd,
	output logic load_ready,
	output logic res_valid,
	output logic res_ok
);
	import fwps_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		load_ready = 1'b0;
		res_valid = 1'b0;
		res_ok = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				load_ready = 1'b1;
				cmd.load = in_fire;
				if (in_fire && in_last) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.trivial_fail) state_d = ST_DONE;
				else begin
					cmd.sort_init = 1'b1;
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_RD: begin
				if (stat.sort_done) begin
					cmd.srch_init = 1'b1;
					state_d = ST_LEVEL_RD;
				end else begin
					cmd.sort_rd = 1'b1;
					state_d = ST_SORT_CMP;
				end
			end
			ST_SORT_CMP: begin
				cmd.sort_cmp = 1'b1;
				if (!stat.sort_shift) state_d = ST_SORT_WR;
			end
			ST_SORT_WR: begin
				cmd.sort_wr = 1'b1;
				state_d = ST_SORT_RD;
			end
			ST_LEVEL_RD: begin
				if (stat.level_end) begin
					if (stat.all_equal) begin
						res_ok = 1'b1;
						state_d = ST_DONE;
					end else state_d = ST_BACK;
				end else begin
					cmd.lvl_rd = 1'b1;
					state_d = ST_TRY;
				end
			end
			ST_TRY: begin
				cmd.try_side = 1'b1;
				if (!stat.sides_left) state_d = ST_BACK;
				else if (stat.side_ok) state_d = ST_LEVEL_RD;
			end
			ST_BACK: begin
				if (stat.at_root) state_d = ST_DONE;
				else begin
					cmd.back = 1'b1;
					state_d = ST_TRY;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (!out_busy) begin
					cmd.clr_set = 1'b1;
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end
endmodule

@@ hw/rtl/fwps_dpath.sv @@
// Datapath: length store, sort and depth-first search registers
module fwps_dpath #(
	parameter int MAX_LENGTHS = 16,
	parameter int LENGTH_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [LENGTH_BITS-1:0] in_len,
	input  fwps_pkg::dp_cmd_t cmd,
	input  logic res_ok,
	output fwps_pkg::dp_stat_t stat,
	output logic success_q,
	output logic overflow_q
);
	import fwps_pkg::*;

	localparam int IW = $clog2(MAX_LENGTHS);
	localparam int CW = $clog2(MAX_LENGTHS + 1);
	localparam int TW = LENGTH_BITS + CW;

	logic [LENGTH_BITS-1:0] mem [MAX_LENGTHS];
	logic [1:0] choice_mem [MAX_LENGTHS];

	logic [CW-1:0] count_q;
	logic [TW-1:0] total_q;
	logic [TW-1:0] side_q [SIDES];
	logic [CW-1:0] lvl_q;
	logic [2:0] side_idx_q;
	logic [LENGTH_BITS-1:0] len_q;
	logic [LENGTH_BITS-1:0] rd_q;
	logic [CW-1:0] sa_q, sb_q;
	logic [LENGTH_BITS-1:0] key_q;
	logic cmp_pend_q;

	// per-side sum for the current candidate, with repeat check
	logic [TW:0] trial;
	logic repeat_hit;
	logic [1:0] sidx;
	logic [TW-1:0] target;
	assign sidx = side_idx_q[1:0];
	assign target = total_q >> 2;
	assign trial = {1'b0, side_q[sidx]} + {{(TW+1-LENGTH_BITS){1'b0}}, len_q};
	always_comb begin
		repeat_hit = 1'b0;
		for (int e = 0; e < SIDES - 1; e++)
			if (e < int'(sidx) && side_q[e] == side_q[sidx]) repeat_hit = 1'b1;
	end

	assign stat.trivial_fail = overflow_q || (count_q < CW'(4)) || (total_q[1:0] != 2'b00);
	assign stat.sort_done = (sa_q >= count_q);
	// sb_q is the hole; compare with mem[sb-1] (rd_q) after read
	assign stat.sort_shift = cmp_pend_q ? 1'b1 : ((sb_q != '0) && (rd_q < key_q));
	assign stat.level_end = (lvl_q >= count_q);
	assign stat.all_equal = (side_q[0] == side_q[1]) && (side_q[1] == side_q[2]) &&
		(side_q[2] == side_q[3]);
	assign stat.sides_left = (side_idx_q < 3'(SIDES));
	assign stat.side_ok = stat.sides_left && (trial <= {1'b0, target}) && !repeat_hit;
	assign stat.at_root = (lvl_q == '0);

	logic [IW-1:0] wa;
	assign wa = count_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load && count_q < CW'(MAX_LENGTHS)) mem[wa] <= in_len;
		if (cmd.sort_rd) begin
			key_q <= mem[sa_q[IW-1:0]];
		end
		if (cmd.sort_cmp) begin
			if (cmp_pend_q) rd_q <= mem[sb_q[IW-1:0] - IW'(1)];
			else if (stat.sort_shift) mem[sb_q[IW-1:0]] <= rd_q;
		end
		if (cmd.sort_wr) mem[sb_q[IW-1:0]] <= key_q;
		if (cmd.lvl_rd) len_q <= mem[lvl_q[IW-1:0]];
		if (cmd.back) len_q <= mem[lvl_q[IW-1:0] - IW'(1)];
		if (cmd.try_side && stat.side_ok) choice_mem[lvl_q[IW-1:0]] <= sidx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			total_q <= '0;
			overflow_q <= 1'b0;
			for (int i = 0; i < SIDES; i++) side_q[i] <= '0;
			lvl_q <= '0;
			side_idx_q <= '0;
			sa_q <= '0;
			sb_q <= '0;
			cmp_pend_q <= 1'b0;
			success_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (count_q < CW'(MAX_LENGTHS)) begin
					count_q <= count_q + CW'(1);
					total_q <= total_q + TW'(in_len);
				end else overflow_q <= 1'b1;
			end
			if (cmd.clr_set) begin
				count_q <= '0;
				total_q <= '0;
				overflow_q <= 1'b0;
				success_q <= 1'b0;
				for (int i = 0; i < SIDES; i++) side_q[i] <= '0;
				lvl_q <= '0;
			end
			if (cmd.sort_init) sa_q <= CW'(1);
			if (cmd.sort_rd) begin
				sb_q <= sa_q;
				cmp_pend_q <= 1'b1;
			end
			if (cmd.sort_cmp) begin
				if (cmp_pend_q) cmp_pend_q <= 1'b0;
				else if (stat.sort_shift) begin
					sb_q <= sb_q - CW'(1);
					cmp_pend_q <= 1'b1;
				end
			end
			// fetch of mem[sb-1] needs sb>0; guard by forcing no shift
			if (cmd.sort_wr) sa_q <= sa_q + CW'(1);
			if (cmd.srch_init) begin
				for (int i = 0; i < SIDES; i++) side_q[i] <= '0;
				lvl_q <= '0;
				side_idx_q <= '0;
			end
			if (cmd.lvl_rd) side_idx_q <= '0;
			if (cmd.try_side) begin
				if (stat.side_ok) begin
					side_q[sidx] <= trial[TW-1:0];
					lvl_q <= lvl_q + CW'(1);
				end else side_idx_q <= side_idx_q + 3'd1;
			end
			if (cmd.back) begin
				// undo the choice of the previous level, then try the next side
				side_q[choice_mem[lvl_q[IW-1:0] - IW'(1)]] <=
					side_q[choice_mem[lvl_q[IW-1:0] - IW'(1)]] -
					TW'(mem[lvl_q[IW-1:0] - IW'(1)]);
				side_idx_q <= {1'b0, choice_mem[lvl_q[IW-1:0] - IW'(1)]} + 3'd1;
				lvl_q <= lvl_q - CW'(1);
			end
			if (res_ok) success_q <= 1'b1;
		end
	end
endmodule

@@ hw/rtl/four_way_equal_partition_search_unit.sv @@
// After the last length, an insertion sort of the lengths runs, then a depth-first
// search of the four sides (one side tried per cycle in the try state).
// Throughput: lengths load one per cycle; a new set loads after the result.
// The sort and search share the length store.
// Reset: arst_n asynchronously clears the set count, total, flags and state.
module four_way_equal_partition_search_unit #(
	parameter int MAX_LENGTHS = 16,
	parameter int LENGTH_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [LENGTH_BITS-1:0] s_tdata, // stick_length
	input  logic s_tlast,                   // is_last
	output logic m_tvalid,
	input  logic m_tready,
	output logic [7:0] m_tdata              // can_form, overflowed, zero fill
);
	import fwps_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic in_fire, res_ok, succ, ovf;

	assign in_fire = s_tvalid && s_tready;

	fwps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_tlast),
		.out_busy(!m_tready), .stat(stat), .cmd(cmd), .load_ready(s_tready),
		.res_valid(m_tvalid), .res_ok(res_ok)
	);

	fwps_dpath #(.MAX_LENGTHS(MAX_LENGTHS), .LENGTH_BITS(LENGTH_BITS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .in_len(s_tdata), .cmd(cmd), .res_ok(res_ok),
		.stat(stat), .success_q(succ), .overflow_q(ovf)
	);

	assign m_tdata = {6'b0, ovf, succ};
endmodule

@@ hw/rtl/fwps_checker.sv @@
// Port-level checker for the partition search unit, bound to the top level
`include "assert_macros.svh"
module fwps_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [7:0] m_tdata
);
	`ASSERT_IMPL(a_no_load_during_result, clk, arst_n, m_tvalid, !s_tready, "load while result pending")
	`ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`ASSERT_IMPL(a_ovf_no_success, clk, arst_n, m_tvalid && m_tdata[1], !m_tdata[0], "success with overflow")
	`ASSERT_IMPL(a_pad_zero, clk, arst_n, m_tvalid, m_tdata[7:2] == 6'b0, "pad bits set")
endmodule

bind four_way_equal_partition_search_unit fwps_checker u_fwps_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// Stream testbench for the four-way equal partition search unit
module testbench;
	localparam int MAX_LENGTHS = 16;
	localparam int LENGTH_BITS = 16;

	typedef struct packed {
		logic [LENGTH_BITS-1:0] stick_length;
		logic                   is_last;
	} stick_t;

	typedef struct packed {
		logic can_form;
		logic overflowed;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [LENGTH_BITS-1:0] s_tdata; // stick_length
	logic s_tlast;                   // is_last
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;             // can_form, overflowed, zero fill

	stick_t   pending_sticks[$];
	verdict_t expected_verdicts[$];

	// predictor state
	logic [LENGTH_BITS-1:0] held_lengths[MAX_LENGTHS];
	int  held_count;
	int  held_total;
	bit  held_overflow;
	int  sides[4];

	int  mismatches;
	int  send_gap;
	int  recv_gap;

	four_way_equal_partition_search_unit #(
		.MAX_LENGTHS(MAX_LENGTHS),
		.LENGTH_BITS(LENGTH_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	function automatic bit place_sticks(int level, int target);
		int e;
		bit repeat_sum;
		if (level >= held_count)
			return sides[0] == sides[1] && sides[1] == sides[2] && sides[2] == sides[3];
		for (int s = 0; s < 4; s++) begin
			if (sides[s] + held_lengths[level] > target)
				continue;
			repeat_sum = 0;
			for (e = 0; e < s; e++)
				if (sides[e] == sides[s])
					repeat_sum = 1;
			if (repeat_sum)
				continue;
			sides[s] += held_lengths[level];
			if (place_sticks(level + 1, target))
				return 1;
			sides[s] -= held_lengths[level];
		end
		return 0;
	endfunction

	function automatic bit partition_verdict();
		logic [LENGTH_BITS-1:0] v;
		int b;
		if (held_overflow || held_count < 4 || (held_total % 4) != 0)
			return 0;
		for (int a = 1; a < held_count; a++) begin
			v = held_lengths[a];
			b = a;
			while (b > 0 && held_lengths[b - 1] < v) begin
				held_lengths[b] = held_lengths[b - 1];
				b--;
			end
			held_lengths[b] = v;
		end
		for (int s = 0; s < 4; s++)
			sides[s] = 0;
		return place_sticks(0, held_total / 4);
	endfunction

	function automatic void predict_stick(stick_t it);
		verdict_t vd;
		if (held_count < MAX_LENGTHS) begin
			held_lengths[held_count] = it.stick_length;
			held_count++;
			held_total += it.stick_length;
		end else begin
			held_overflow = 1;
		end
		if (it.is_last) begin
			vd.can_form = partition_verdict();
			vd.overflowed = held_overflow;
			expected_verdicts.push_back(vd);
			held_count = 0;
			held_total = 0;
			held_overflow = 0;
		end
	endfunction

	task automatic queue_set(int lens[$]);
		stick_t it;
		foreach (lens[i]) begin
			it.stick_length = LENGTH_BITS'(lens[i]);
			it.is_last = (i == lens.size() - 1);
			pending_sticks.push_back(it);
		end
	endtask

	// builds a set whose lengths split into four sides of equal sum
	task automatic queue_solvable_set(int n, int maxlen);
		int lens[$];
		int side_len;
		int rem;
		int pieces;
		int cut;
		side_len = $urandom_range(n / 4, maxlen);
		for (int s = 0; s < 4; s++) begin
			pieces = (s < n % 4) ? n / 4 + 1 : n / 4;
			rem = side_len;
			for (int p = 0; p < pieces - 1; p++) begin
				cut = $urandom_range(0, rem);
				lens.push_back(cut);
				rem -= cut;
			end
			lens.push_back(rem);
		end
		lens.shuffle();
		queue_set(lens);
	endtask

	task automatic queue_random_set(int n, int maxlen);
		int lens[$];
		for (int i = 0; i < n; i++)
			lens.push_back($urandom_range(0, maxlen));
		queue_set(lens);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("testbench failed");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		stick_t it;
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata <= '0;
			s_tlast <= 0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				predict_stick({s_tdata, s_tlast});
			if (send_gap > 0 || pending_sticks.size() == 0) begin
				s_tvalid <= 0;
				if (send_gap > 0)
					send_gap <= send_gap - 1;
			end else begin
				it = pending_sticks.pop_front();
				s_tvalid <= 1;
				s_tdata <= it.stick_length;
				s_tlast <= it.is_last;
				send_gap <= pick_gap();
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		verdict_t exp_v;
		verdict_t got;
		if (!arst_n) begin
			m_tready <= 0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.can_form = m_tdata[0];
				got.overflowed = m_tdata[1];
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer %b", m_tdata);
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (got != exp_v || m_tdata[7:2] != 0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected can_form=%0d overflowed=%0d, got %b",
								exp_v.can_form, exp_v.overflowed, m_tdata);
					end
				end
			end
			if (recv_gap > 0) begin
				m_tready <= 0;
				recv_gap <= recv_gap - 1;
			end else begin
				m_tready <= 1;
				recv_gap <= pick_gap();
			end
		end
	end

	initial begin
		int n;
		int r;
		int lens[$];
		mismatches = 0;
		held_count = 0;
		held_total = 0;
		held_overflow = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed sets
		queue_set('{0, 0, 0, 0});
		queue_set('{65535, 65535, 65535, 65535});
		queue_set('{1, 1, 2});
		queue_set('{5});
		queue_set('{1, 1, 1, 2});
		queue_set('{3, 3, 3, 3, 4, 4, 4, 4});
		lens = {};
		for (int i = 0; i < MAX_LENGTHS + 2; i++)
			lens.push_back(1);
		queue_set(lens);
		queue_set('{32768, 32767, 1, 32768, 32768, 0});

		while (pending_sticks.size() < 1600) begin
			r = $urandom_range(0, 99);
			n = (r < 5) ? $urandom_range(MAX_LENGTHS + 1, MAX_LENGTHS + 3)
				: $urandom_range(4, (r < 85) ? 10 : MAX_LENGTHS);
			if (r < 50)
				queue_solvable_set(n, (r < 25) ? 40 : 65535);
			else if (r < 90)
				queue_random_set($urandom_range(1, n), (r < 70) ? 8 : 65535);
			else
				queue_random_set(n, 65535);
		end

		wait (pending_sticks.size() == 0 && !s_tvalid);
		wait (expected_verdicts.size() == 0);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/fwps_pkg.sv
hw/rtl/fwps_ctrl.sv
hw/rtl/fwps_dpath.sv
hw/rtl/four_way_equal_partition_search_unit.sv
hw/rtl/fwps_checker.sv
dv/testbench.sv
